// File: rtl/fcno_pkg.sv
// shared types, constants and helpers of the face centroid and normal offset unit
package fcno_pkg;

    localparam int MAX_FACE_VERTICES = 40;
    localparam int CNT_W             = 7;
    localparam int PSUM_W            = 40;
    localparam int ACC_W             = 64;
    localparam int Q_DEPTH           = 2;
    localparam int Q_AW              = $clog2(Q_DEPTH);
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 16;

    localparam logic signed [CFG_DATA_W-1:0] SCALE_RESET = 16'sd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE = 2'd0,
        CFG_MODE  = 2'd1,
        CFG_NORM  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0][PSUM_W-1:0] psum;
        logic [2:0][ACC_W-1:0]  acc;
        logic [CNT_W-1:0]       cnt;
        logic                   ovf;
    } t_face;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/fcno_in_if.sv
// vertex request channel
interface fcno_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic signed [31:0] vnormal_x;
    logic signed [31:0] vnormal_y;
    logic signed [31:0] vnormal_z;
    logic               last_vertex;

    modport source (output valid, vertex_x, vertex_y, vertex_z, vnormal_x, vnormal_y,
                    vnormal_z, last_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, vnormal_x, vnormal_y,
                    vnormal_z, last_vertex, output ready);
endinterface

// File: rtl/fcno_out_if.sv
// apex point and normal result channel
interface fcno_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic               too_many_vertices;

    modport source (output valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
                    too_many_vertices, input ready);
    modport sink   (input valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
                    too_many_vertices, output ready);
endinterface

// File: rtl/face_centroid_normal_offset_unit.sv
// top level of the face centroid and normal offset unit
// front end: normal-sum mode needs no products; in cross mode each vertex from the third on runs
//   through one shared 33x33 multiplier (six products per edge pair), and a last vertex adds two wrap-around pairs
// back end: six 64-step serial divides per face, and with normalizing also a shift search,
//   a 32-step square root and three more divides
// synchronous active-low reset clears face sums, queue, result valid and config
module face_centroid_normal_offset_unit
    import fcno_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fcno_in_if.sink               i_vtx,
    fcno_out_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic signed [15:0] r_scale;
    logic               r_mode;
    logic               r_norm;

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    t_face front_face;
    t_face back_face;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_mode  <= 1'b0;
            r_norm  <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SCALE) begin
                r_scale <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_MODE) begin
                r_mode <= i_cfg_data[0];
            end
            if (i_cfg_idx == CFG_NORM) begin
                r_norm <= i_cfg_data[0];
            end
        end
    end

    fcno_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (i_vtx),
        .i_mode  (r_mode),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_face  (front_face)
    );

    fcno_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_face  (front_face),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_face  (back_face)
    );

    fcno_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_face  (back_face),
        .o_pop   (q_pop),
        .i_scale (r_scale),
        .i_norm  (r_norm),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("face queue written while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("face queue read while empty");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");
`endif

endmodule

// File: rtl/fcno_div.sv
// bit-serial signed divider, 64-bit dividend by 32-bit unsigned divisor, truncating
module fcno_div
    import fcno_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_dividend,
    input  logic        [31:0] i_divisor,
    output logic               o_done,
    output logic signed [63:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic        r_neg;

    logic [63:0] mag;
    logic [32:0] trial;
    logic        take;

    assign mag   = i_dividend[63] ? 64'(-i_dividend) : 64'(i_dividend);
    assign trial = {r_rem, r_quo[63]};
    assign take  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == 7'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_quo  <= mag;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_neg  <= i_dividend[63];
            end else if (r_busy) begin
                r_rem <= take ? 32'(trial - {1'b0, r_div}) : trial[31:0];
                r_quo <= {r_quo[62:0], take};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

// File: rtl/fcno_front.sv
// front end: takes vertices, keeps running sums and edge cross products of a face
module fcno_front
    import fcno_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    fcno_in_if.sink i_vtx,
    input  logic    i_mode,
    input  logic    i_full,
    output logic    o_push,
    output t_face   o_face
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_NEXT = 3'b100
    } t_fstate;

    localparam logic [2:0] LAST_STEP = 3'd6;

    t_fstate                  r_state;
    logic signed [PSUM_W-1:0] r_psum [3];
    logic signed [ACC_W-1:0]  r_acc [3];
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_ovf;
    logic                     r_last;
    logic [1:0]               r_wrap;
    logic [2:0]               r_step;
    logic signed [31:0]       r_first0 [3];
    logic signed [31:0]       r_first1 [3];
    logic signed [31:0]       r_prev0 [3];
    logic signed [31:0]       r_prev1 [3];
    logic signed [32:0]       r_d1 [3];
    logic signed [32:0]       r_d2 [3];
    logic signed [65:0]       r_prod;

    logic                     accept;
    logic                     can_add;
    logic                     need_vx;
    logic                     need_wrap;
    logic signed [31:0]       pos [3];
    logic signed [31:0]       nrm [3];
    logic signed [31:0]       wa [3];
    logic signed [31:0]       wb [3];
    logic signed [31:0]       wc [3];
    logic signed [32:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic [2:0]               prev_step;
    logic [1:0]               acc_k;
    logic signed [ACC_W-1:0]  term;

    assign pos[0] = i_vtx.vertex_x;
    assign pos[1] = i_vtx.vertex_y;
    assign pos[2] = i_vtx.vertex_z;
    assign nrm[0] = i_vtx.vnormal_x;
    assign nrm[1] = i_vtx.vnormal_y;
    assign nrm[2] = i_vtx.vnormal_z;

    assign i_vtx.ready = (r_state == F_IDLE);
    assign accept      = i_vtx.valid && i_vtx.ready;
    assign can_add     = r_cnt < CNT_W'(MAX_FACE_VERTICES);
    assign need_vx     = i_mode && can_add && (r_cnt >= CNT_W'(2));
    assign need_wrap   = r_last && i_mode && (r_cnt >= CNT_W'(3)) && (r_wrap != 2'd2);
    assign o_push      = (r_state == F_NEXT) && r_last && !need_wrap && !i_full;

    // wrap-around triples: (p[n-2], p[n-1], p0) then (p[n-1], p0, p1)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_wrap == 2'd0) begin
                wa[k] = r_prev0[k];
                wb[k] = r_prev1[k];
                wc[k] = r_first0[k];
            end else begin
                wa[k] = r_prev1[k];
                wb[k] = r_first0[k];
                wc[k] = r_first1[k];
            end
        end
    end

    always_comb begin
        unique case (r_step)
            3'd0:    begin mul_a = r_d1[1]; mul_b = r_d2[2]; end
            3'd1:    begin mul_a = r_d1[2]; mul_b = r_d2[1]; end
            3'd2:    begin mul_a = r_d1[2]; mul_b = r_d2[0]; end
            3'd3:    begin mul_a = r_d1[0]; mul_b = r_d2[2]; end
            3'd4:    begin mul_a = r_d1[0]; mul_b = r_d2[1]; end
            default: begin mul_a = r_d1[1]; mul_b = r_d2[0]; end
        endcase
    end

    assign prev_step = r_step - 3'd1;
    assign acc_k     = prev_step[2:1];
    assign term      = ACC_W'($signed(r_prod[65:16]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_last  <= 1'b0;
            r_wrap  <= '0;
            r_step  <= '0;
            for (int k = 0; k < 3; k++) begin
                r_psum[k] <= '0;
                r_acc[k]  <= '0;
            end
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        if (can_add) begin
                            for (int k = 0; k < 3; k++) begin
                                r_psum[k]  <= r_psum[k] + PSUM_W'(pos[k]);
                                if (!i_mode) begin
                                    r_acc[k] <= r_acc[k] + ACC_W'(nrm[k]);
                                end
                                if (r_cnt == CNT_W'(0)) begin
                                    r_first0[k] <= pos[k];
                                end else if (r_cnt == CNT_W'(1)) begin
                                    r_first1[k] <= pos[k];
                                end
                                r_prev0[k] <= r_prev1[k];
                                r_prev1[k] <= pos[k];
                                r_d1[k]    <= 33'(r_prev0[k]) - 33'(r_prev1[k]);
                                r_d2[k]    <= 33'(r_prev1[k]) - 33'(pos[k]);
                            end
                            r_cnt <= r_cnt + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        r_last <= i_vtx.last_vertex;
                        r_wrap <= '0;
                        r_step <= '0;
                        if (need_vx) begin
                            r_state <= F_MUL;
                        end else if (i_vtx.last_vertex) begin
                            r_state <= F_NEXT;
                        end
                    end
                end
                F_MUL: begin
                    if (r_step != LAST_STEP) begin
                        r_prod <= 66'(mul_a) * 66'(mul_b);
                    end
                    if (r_step != 3'd0) begin
                        r_acc[acc_k] <= prev_step[0] ? r_acc[acc_k] - term
                                                     : r_acc[acc_k] + term;
                    end
                    if (r_step == LAST_STEP) begin
                        r_state <= F_NEXT;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                F_NEXT: begin
                    if (need_wrap) begin
                        for (int k = 0; k < 3; k++) begin
                            r_d1[k] <= 33'(wa[k]) - 33'(wb[k]);
                            r_d2[k] <= 33'(wb[k]) - 33'(wc[k]);
                        end
                        r_wrap  <= r_wrap + 2'd1;
                        r_step  <= '0;
                        r_state <= F_MUL;
                    end else if (!r_last) begin
                        r_state <= F_IDLE;
                    end else if (!i_full) begin
                        for (int k = 0; k < 3; k++) begin
                            r_psum[k] <= '0;
                            r_acc[k]  <= '0;
                        end
                        r_cnt   <= '0;
                        r_ovf   <= 1'b0;
                        r_last  <= 1'b0;
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_face.psum[k] = r_psum[k];
            o_face.acc[k]  = r_acc[k];
        end
        o_face.cnt = r_cnt;
        o_face.ovf = r_ovf;
    end

endmodule

// File: rtl/fcno_queue.sv
// short queue of finished face sums between front and back end
module fcno_queue
    import fcno_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_face i_face,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_face o_face
);

    t_face           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = r_cnt == (Q_AW+1)'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_face  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_face;
                r_wp        <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

endmodule

// File: rtl/fcno_back.sv
// back end: averages, scales, optionally normalizes and emits one apex point and normal per face
module fcno_back
    import fcno_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  t_face                  i_face,
    output logic                   o_pop,
    input  logic signed [15:0]     i_scale,
    input  logic                   i_norm,
    fcno_out_if.source             o_res
);

    typedef enum logic [8:0] {
        B_IDLE  = 9'b000000001,
        B_DIV   = 9'b000000010,
        B_SCALE = 9'b000000100,
        B_POINT = 9'b000001000,
        B_MAX   = 9'b000010000,
        B_SHIFT = 9'b000100000,
        B_SQ    = 9'b001000000,
        B_SQRT  = 9'b010000000,
        B_OUT   = 9'b100000000
    } t_bstate;

    typedef enum logic [1:0] {
        G_ACC = 2'd0,
        G_POS = 2'd1,
        G_NRM = 2'd2
    } t_grp;

    localparam int                OFF_W   = 57;
    localparam int                T_W     = 49;
    localparam int                M_W     = 56;
    localparam logic signed [63:0] T_LIM  = 64'sh0000_8000_0000_0000;
    localparam logic [M_W-1:0]    M_HI    = M_W'(1) << 30;
    localparam logic [M_W-1:0]    M_LO    = M_W'(1) << 29;
    localparam logic [63:0]       BIT_TOP = 64'd1 << 62;

    t_bstate                  r_state;
    t_grp                     r_grp;
    logic [1:0]               r_k;
    logic                     r_go;
    logic signed [ACC_W-1:0]  r_acc [3];
    logic signed [PSUM_W-1:0] r_psum [3];
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_ovf;
    logic signed [T_W-1:0]    r_t [3];
    logic signed [PSUM_W-1:0] r_cen [3];
    logic signed [64:0]       r_sprod;
    logic signed [OFF_W-1:0]  r_off [3];
    logic signed [OFF_W-1:0]  r_c [3];
    logic [M_W-1:0]           r_m;
    logic [63:0]              r_sqp;
    logic [63:0]              r_ss;
    logic [63:0]              r_root;
    logic [63:0]              r_bit;
    logic [31:0]              r_len;
    logic signed [31:0]       r_pt [3];
    logic signed [31:0]       r_nv [3];
    logic                     r_ovalid;
    logic signed [31:0]       r_opt [3];
    logic signed [31:0]       r_onv [3];
    logic                     r_oovf;

    logic                     div_start;
    logic signed [63:0]       div_num;
    logic [31:0]              div_den;
    logic                     div_done;
    logic signed [63:0]       div_quo;
    logic signed [63:0]       t_sel;
    logic [1:0]               k_safe;
    logic [OFF_W-1:0]         abs_off [3];
    logic [M_W-1:0]           max_off;
    logic signed [31:0]       sq_in;
    logic signed [63:0]       sq_full;
    logic [63:0]              root_try;

    fcno_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign k_safe    = (r_k == 2'd3) ? 2'd0 : r_k;
    assign div_start = (r_state == B_DIV) && r_go;
    assign o_pop     = (r_state == B_IDLE) && !i_empty;

    always_comb begin
        unique case (r_grp)
            G_ACC:   div_num = r_acc[k_safe];
            G_POS:   div_num = 64'(r_psum[k_safe]);
            default: div_num = {{16{r_c[k_safe][31]}}, r_c[k_safe][31:0], 16'b0};
        endcase
        div_den = (r_grp == G_NRM) ? r_len : 32'(r_cnt);
    end

    // averaged offset, zero below three vertices, clamped to +-2^47
    always_comb begin
        if (r_cnt < CNT_W'(3)) begin
            t_sel = '0;
        end else if (div_quo > T_LIM) begin
            t_sel = T_LIM;
        end else if (div_quo < -T_LIM) begin
            t_sel = -T_LIM;
        end else begin
            t_sel = div_quo;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            abs_off[k] = r_off[k][OFF_W-1] ? OFF_W'(-r_off[k]) : OFF_W'(r_off[k]);
        end
        max_off = abs_off[0][M_W-1:0];
        if (abs_off[1][M_W-1:0] > max_off) begin
            max_off = abs_off[1][M_W-1:0];
        end
        if (abs_off[2][M_W-1:0] > max_off) begin
            max_off = abs_off[2][M_W-1:0];
        end
    end

    assign sq_in    = r_c[k_safe][31:0];
    assign sq_full  = sq_in * sq_in;
    assign root_try = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
            r_grp    <= G_ACC;
            r_k      <= '0;
        end else begin
            if (r_ovalid && o_res.ready && (r_state != B_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        for (int k = 0; k < 3; k++) begin
                            r_acc[k]  <= i_face.acc[k];
                            r_psum[k] <= i_face.psum[k];
                        end
                        r_cnt   <= i_face.cnt;
                        r_ovf   <= i_face.ovf;
                        r_grp   <= G_ACC;
                        r_k     <= '0;
                        r_go    <= 1'b1;
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    if (r_go) begin
                        r_go <= 1'b0;
                    end
                    if (div_done) begin
                        unique case (r_grp)
                            G_ACC:   r_t[k_safe]   <= t_sel[T_W-1:0];
                            G_POS:   r_cen[k_safe] <= div_quo[PSUM_W-1:0];
                            default: r_nv[k_safe]  <= sat32(div_quo);
                        endcase
                        if (r_k != 2'd2) begin
                            r_k  <= r_k + 2'd1;
                            r_go <= 1'b1;
                        end else begin
                            r_k <= '0;
                            unique case (r_grp)
                                G_ACC: begin
                                    r_grp <= G_POS;
                                    r_go  <= 1'b1;
                                end
                                G_POS:   r_state <= B_SCALE;
                                default: r_state <= B_OUT;
                            endcase
                        end
                    end
                end
                B_SCALE: begin
                    if (r_k != 2'd3) begin
                        r_sprod <= 65'(r_t[k_safe]) * 65'(i_scale);
                    end
                    if (r_k != 2'd0) begin
                        r_off[r_k - 2'd1] <= r_sprod[64:8];
                    end
                    if (r_k == 2'd3) begin
                        r_k     <= '0;
                        r_state <= B_POINT;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                B_POINT: begin
                    for (int k = 0; k < 3; k++) begin
                        r_pt[k] <= sat32(64'(r_cen[k]) + 64'(r_off[k]));
                        r_nv[k] <= sat32(64'(r_off[k]));
                    end
                    r_state <= i_norm ? B_MAX : B_OUT;
                end
                B_MAX: begin
                    r_m <= max_off;
                    for (int k = 0; k < 3; k++) begin
                        r_c[k] <= r_off[k];
                    end
                    r_state <= (max_off == '0) ? B_OUT : B_SHIFT;
                end
                B_SHIFT: begin
                    if (r_m >= M_HI) begin
                        for (int k = 0; k < 3; k++) begin
                            r_c[k] <= r_c[k] >>> 1;
                        end
                        r_m <= r_m >> 1;
                    end else if (r_m < M_LO) begin
                        for (int k = 0; k < 3; k++) begin
                            r_c[k] <= r_c[k] <<< 1;
                        end
                        r_m <= r_m << 1;
                    end else begin
                        r_k     <= '0;
                        r_ss    <= '0;
                        r_state <= B_SQ;
                    end
                end
                B_SQ: begin
                    if (r_k != 2'd3) begin
                        r_sqp <= sq_full;
                    end
                    if (r_k != 2'd0) begin
                        r_ss <= r_ss + r_sqp;
                    end
                    if (r_k == 2'd3) begin
                        r_k     <= '0;
                        r_root  <= '0;
                        r_bit   <= BIT_TOP;
                        r_state <= B_SQRT;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                B_SQRT: begin
                    if (r_bit == '0) begin
                        r_len   <= (r_root == '0) ? 32'd1 : r_root[31:0];
                        r_grp   <= G_NRM;
                        r_k     <= '0;
                        r_go    <= 1'b1;
                        r_state <= B_DIV;
                    end else begin
                        if (r_ss >= root_try) begin
                            r_ss   <= r_ss - root_try;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                B_OUT: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_opt    <= r_pt;
                        r_onv    <= r_nv;
                        r_oovf   <= r_ovf;
                        r_ovalid <= 1'b1;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_res.valid             = r_ovalid;
    assign o_res.point_x           = r_opt[0];
    assign o_res.point_y           = r_opt[1];
    assign o_res.point_z           = r_opt[2];
    assign o_res.normal_x          = r_onv[0];
    assign o_res.normal_y          = r_onv[1];
    assign o_res.normal_z          = r_onv[2];
    assign o_res.too_many_vertices = r_oovf;

endmodule
